/* rtl/mrfi_pkg.sv */
// ----------------------------------------------------------------------------
// mrfi_pkg
// Shared types and constants of the message ring with front insert.
// ----------------------------------------------------------------------------
package mrfi_pkg;

  localparam int unsigned DepthDef       = 16;
  localparam int unsigned MessageWidthDef = 32;

  // operation codes
  localparam logic [1:0] OP_GET       = 2'd0;
  localparam logic [1:0] OP_PUT_BACK  = 2'd1;
  localparam logic [1:0] OP_PUT_FRONT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] op;
    logic       waiter;
  } ctrl_t;

endpackage

/* rtl/message_ring_with_front_insert.sv */
// ----------------------------------------------------------------------------
// message_ring_with_front_insert
// Mailbox ring of messages with get, put at back and put at front.
// ----------------------------------------------------------------------------
// Operations arrive on the in channel (operation, message, waiter_present)
// and each gives exactly one result on the out channel (status,
// message_out, handed_to_waiter, fill_count), in order.
// The capacity register is written over the cfg channel, which is always
// ready; a write clamps the value to 1..DEPTH and empties the ring. Write it
// only while no operation is in flight.
// A result passes through the input register and then the ring stage, whose
// result register presents it on the out channel.
// Throughput: one operation per cycle unless the receiver stalls; the slot
// memory has one write port and one registered read port, and each operation
// uses at most one of each.
// Reset empties the ring and sets the capacity to DEPTH; slot contents are
// not cleared, and only written slots ever reach message_out_o.
// When the receiver stalls, the result register holds its result, the ring
// stage stops, and in_ready_o drops once the input register holds an
// operation.
// ----------------------------------------------------------------------------
module message_ring_with_front_insert #(
  parameter int unsigned DEPTH         = mrfi_pkg::DepthDef,
  parameter int unsigned MESSAGE_WIDTH = mrfi_pkg::MessageWidthDef,
  localparam int unsigned CntW         = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CntW-1:0]          capacity_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic [MESSAGE_WIDTH-1:0] message_i,
  input  logic                     waiter_present_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [MESSAGE_WIDTH-1:0] message_out_o,
  output logic                     handed_to_waiter_o,
  output logic [CntW-1:0]          fill_count_o
);
  import mrfi_pkg::*;

  ctrl_t                    in_ctrl, s_ctrl;
  logic                     s_valid, s_ready;
  logic [MESSAGE_WIDTH-1:0] s_msg;

  assign cfg_ready_o    = 1'b1;
  assign in_ctrl.op     = operation_i;
  assign in_ctrl.waiter = waiter_present_i;

  mrfi_in_stage #(
    .MessageWidth(MESSAGE_WIDTH)
  ) u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .ctrl_i    (in_ctrl),
    .msg_i     (message_i),
    .s_valid_o (s_valid),
    .s_ready_i (s_ready),
    .ctrl_o    (s_ctrl),
    .msg_o     (s_msg)
  );

  mrfi_ring #(
    .Depth       (DEPTH),
    .MessageWidth(MESSAGE_WIDTH)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (capacity_i),
    .s_valid_i    (s_valid),
    .s_ready_o    (s_ready),
    .ctrl_i       (s_ctrl),
    .msg_i        (s_msg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .message_out_o(message_out_o),
    .handed_o     (handed_to_waiter_o),
    .fill_o       (fill_count_o)
  );

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_count_o <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      fill_count_o == '0 && message_out_o == '0 && !handed_to_waiter_o)
    else $error("empty get with data");

  a_handover_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handed_to_waiter_o |-> status_o == ST_OK)
    else $error("handover with error status");

  a_full_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      fill_count_o != '0 && message_out_o == '0)
    else $error("full put with empty ring or data");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid && !s_ready |=> s_valid && $stable(s_ctrl) && $stable(s_msg))
    else $error("input register lost a stalled transfer");

endmodule

/* rtl/mrfi_in_stage.sv */
// ----------------------------------------------------------------------------
// mrfi_in_stage
// Input register: holds one operation until the ring stage takes it.
// ----------------------------------------------------------------------------
module mrfi_in_stage #(
  parameter int unsigned MessageWidth = mrfi_pkg::MessageWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mrfi_pkg::ctrl_t         ctrl_i,
  input  logic [MessageWidth-1:0] msg_i,
  output logic                    s_valid_o,
  input  logic                    s_ready_i,
  output mrfi_pkg::ctrl_t         ctrl_o,
  output logic [MessageWidth-1:0] msg_o
);
  import mrfi_pkg::*;

  logic                    valid_q;
  ctrl_t                   ctrl_q;
  logic [MessageWidth-1:0] msg_q;

  assign in_ready_o = !valid_q || s_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ctrl_q <= ctrl_i;
      msg_q  <= msg_i;
    end
  end

  assign s_valid_o = valid_q;
  assign ctrl_o    = ctrl_q;
  assign msg_o     = msg_q;

endmodule

/* rtl/mrfi_ring.sv */
// ----------------------------------------------------------------------------
// mrfi_ring
// Ring state, slot memory and result register; one operation per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
module mrfi_ring #(
  parameter int unsigned Depth        = mrfi_pkg::DepthDef,
  parameter int unsigned MessageWidth = mrfi_pkg::MessageWidthDef,
  localparam int unsigned CntW        = $clog2(Depth + 1),
  localparam int unsigned PtrW        = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [CntW-1:0]         cfg_data_i,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  mrfi_pkg::ctrl_t         ctrl_i,
  input  logic [MessageWidth-1:0] msg_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [MessageWidth-1:0] message_out_o,
  output logic                    handed_o,
  output logic [CntW-1:0]         fill_o
);
  import mrfi_pkg::*;

  logic [MessageWidth-1:0] mem [Depth];

  logic [CntW-1:0] cap_q, count_q, count_d, cap_cfg;
  logic [PtrW-1:0] rd_q, rd_d, wp_q, wp_d, wr_addr;
  logic [CntW-1:0] rd_inc, wp_inc;
  logic            fire, wr_en, sel_mem, handed;
  status_e         status;

  logic                    out_valid_q, sel_mem_q, handed_q;
  status_e                 status_q;
  logic [CntW-1:0]         fill_q;
  logic [MessageWidth-1:0] rd_data_q, bypass_q;

  assign s_ready_o = !out_valid_q || out_ready_i;
  assign fire      = s_valid_i && s_ready_o;

  assign rd_inc = CntW'(rd_q) + CntW'(1);
  assign wp_inc = CntW'(wp_q) + CntW'(1);

  always_comb begin
    if (cfg_data_i == '0) begin
      cap_cfg = CntW'(1);
    end else if (cfg_data_i > CntW'(Depth)) begin
      cap_cfg = CntW'(Depth);
    end else begin
      cap_cfg = cfg_data_i;
    end
  end

  always_comb begin
    rd_d    = rd_q;
    wp_d    = wp_q;
    count_d = count_q;
    status  = ST_OK;
    handed  = 1'b0;
    sel_mem = 1'b0;
    wr_en   = 1'b0;
    wr_addr = wp_q;
    if (ctrl_i.op == OP_GET) begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else begin
        sel_mem = 1'b1;
        count_d = count_q - CntW'(1);
        rd_d    = (rd_inc >= cap_q) ? '0 : PtrW'(rd_inc);
      end
    end else if (ctrl_i.waiter) begin
      handed = 1'b1;
    end else if (count_q >= cap_q) begin
      status = ST_FULL;
    end else if (ctrl_i.op != OP_PUT_BACK) begin
      // front insert (also taken by the spare code): step the read pointer back and store there
      rd_d    = (rd_q == '0) ? PtrW'(cap_q - CntW'(1)) : rd_q - PtrW'(1);
      wr_en   = 1'b1;
      wr_addr = rd_d;
      count_d = count_q + CntW'(1);
    end else begin
      wr_en   = 1'b1;
      wr_addr = wp_q;
      wp_d    = (wp_inc >= cap_q) ? '0 : PtrW'(wp_inc);
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CntW'(Depth);
      rd_q    <= '0;
      wp_q    <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      cap_q   <= cap_cfg;
      rd_q    <= '0;
      wp_q    <= '0;
      count_q <= '0;
    end else if (fire) begin
      rd_q    <= rd_d;
      wp_q    <= wp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      mem[wr_addr] <= msg_i;
    end
    if (fire) begin
      rd_data_q <= mem[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      out_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status;
      handed_q  <= handed;
      sel_mem_q <= sel_mem;
      fill_q    <= count_d;
      bypass_q  <= msg_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign handed_o      = handed_q;
  assign fill_o        = fill_q;
  assign message_out_o = sel_mem_q ? rd_data_q : (handed_q ? bypass_q : '0);

endmodule

/* verif/tb_message_ring_with_front_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_ring_with_front_insert
// Self-checking bench for the mailbox message ring with front insert.
// ----------------------------------------------------------------------------
// Operations go through the in channel in bursts with random or no gaps. Results are
// drained through the out channel while the ready line follows a changing
// stall pattern. A behavioral copy of the ring (slots, pointers, count,
// capacity) predicts each result at the moment its operation is transferred.
// Each result is checked field by field against the oldest prediction. The
// directed tests cover empty gets, full puts, the front-insert wrap, waiter
// hand-over, the spare operation code and capacity clamping. The random test
// then runs put-heavy and get-heavy traffic under many capacities.
// ----------------------------------------------------------------------------
module tb_message_ring_with_front_insert;
  import mrfi_pkg::*;

  localparam int unsigned RING_DEPTH = DepthDef;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    status_e     status;
    logic [31:0] message;
    logic        handed;
    logic [4:0]  fill;
  } ring_result_t;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_LONG_STALL} ready_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  capacity_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_GET;
  logic [31:0] message_i = '0;
  logic        waiter_present_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [1:0]  status_o;
  logic [31:0] message_out_o;
  logic        handed_to_waiter_o;
  logic [4:0]  fill_count_o;

  // behavioral ring
  logic [31:0] slot_mem [RING_DEPTH];
  int unsigned ring_cap = RING_DEPTH;
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned held = 0;

  ring_result_t ring_results_q[$];
  ring_result_t oldest_result;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned empty_gets = 0;
  int unsigned full_puts = 0;
  int unsigned handovers = 0;
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;
  int unsigned ready_tick = 0;
  ready_pattern_e ready_pattern = RDY_ALWAYS;

  message_ring_with_front_insert dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .capacity_i         (capacity_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .message_i          (message_i),
    .waiter_present_i   (waiter_present_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .message_out_o      (message_out_o),
    .handed_to_waiter_o (handed_to_waiter_o),
    .fill_count_o       (fill_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    ready_tick++;
    if (ready_tick % 50 == 0) begin
      ready_pattern = ready_pattern_e'($urandom_range(0, 3));
    end
    case (ready_pattern)
      RDY_ALWAYS:     out_ready_i <= 1'b1;
      RDY_RANDOM:     out_ready_i <= 1'($urandom_range(0, 1));
      RDY_PERIODIC:   out_ready_i <= (ready_tick % 4) != 0;
      default:        out_ready_i <= (ready_tick % 16) >= 6;
    endcase
  end

  function automatic ring_result_t apply_ring_op(input logic [1:0] op,
                                                 input logic [31:0] msg,
                                                 input logic waiter);
    ring_result_t res;
    res.status  = ST_OK;
    res.message = '0;
    res.handed  = 1'b0;
    if (op == OP_GET) begin
      if (held == 0) begin
        res.status = ST_EMPTY;
        empty_gets++;
      end else begin
        res.message = slot_mem[rd_ptr];
        held--;
        rd_ptr = (rd_ptr + 1 >= ring_cap) ? 0 : rd_ptr + 1;
      end
    end else if (waiter) begin
      res.message = msg;
      res.handed  = 1'b1;
      handovers++;
    end else if (held >= ring_cap) begin
      res.status = ST_FULL;
      full_puts++;
    end else if (op[1]) begin
      rd_ptr = (rd_ptr == 0) ? ring_cap - 1 : rd_ptr - 1;
      slot_mem[rd_ptr] = msg;
      held++;
    end else begin
      slot_mem[wr_ptr] = msg;
      wr_ptr = (wr_ptr + 1 >= ring_cap) ? 0 : wr_ptr + 1;
      held++;
    end
    res.fill = held[4:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (ring_results_q.size() == 0) begin
        $error("result transfer with no operation pending");
        error_count++;
      end else begin
        oldest_result = ring_results_q.pop_front();
        if (status_o !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, status_o);
          error_count++;
        end
        if (message_out_o !== oldest_result.message) begin
          $error("message_out: expected %h, got %h", oldest_result.message, message_out_o);
          error_count++;
        end
        if (handed_to_waiter_o !== oldest_result.handed) begin
          $error("handed_to_waiter: expected %0d, got %0d", oldest_result.handed,
                 handed_to_waiter_o);
          error_count++;
        end
        if (fill_count_o !== oldest_result.fill) begin
          $error("fill_count: expected %0d, got %0d", oldest_result.fill, fill_count_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] msg, input logic waiter);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_steady ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i) in_valid_i <= 1'b0;
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    message_i        <= msg;
    waiter_present_i <= waiter;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ring_results_q.push_back(apply_ring_op(op, msg, waiter));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    capacity_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (value == 0) ring_cap = 1;
    else if (32'(value) > RING_DEPTH) ring_cap = RING_DEPTH;
    else ring_cap = 32'(value);
    rd_ptr = 0;
    wr_ptr = 0;
    held   = 0;
    cfg_writes++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // capacity 16 from reset, front insert wraps to the top slot
  task automatic test_reset_capacity();
    send_item(OP_GET, 32'h1357_9bdf, 1'b0);
    send_item(OP_PUT_BACK, 32'h0000_0000, 1'b0);
    send_item(OP_PUT_FRONT, 32'hffff_ffff, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
    send_item(OP_GET, 32'hdead_beef, 1'b1);
  endtask

  // zero capacity clamps to one slot; full ring with and without a waiter
  task automatic test_single_slot();
    write_capacity(5'd0);
    send_item(OP_PUT_BACK, 32'ha5a5_a5a5, 1'b0);
    send_item(OP_PUT_BACK, 32'h5a5a_5a5a, 1'b0);
    send_item(OP_PUT_FRONT, 32'h8000_0001, 1'b1);
    send_item(OP_PUT_FRONT, 32'h7fff_fffe, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
  endtask

  task automatic test_spare_code();
    write_capacity(5'd2);
    send_item(OP_SPARE, 32'h0000_0001, 1'b0);
    send_item(OP_PUT_BACK, 32'h0000_0002, 1'b0);
    send_item(OP_SPARE, 32'h0000_0003, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
  endtask

  // values above the depth clamp to the depth
  task automatic test_oversize_capacity();
    write_capacity(5'd31);
    send_item(OP_PUT_BACK, 32'h1234_5678, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
    write_capacity(5'd17);
    send_item(OP_PUT_FRONT, 32'hcafe_f00d, 1'b0);
    send_item(OP_GET, 32'h0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned put_pct;
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] msg;
    logic [4:0]  cap_value;
    for (int phase = 0; phase < 14; phase++) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0:       cap_value = 5'($urandom_range(1, 4));
        1:       cap_value = 5'(RING_DEPTH);
        2:       cap_value = 5'($urandom_range(0, 31));
        default: cap_value = 5'($urandom_range(5, 15));
      endcase
      write_capacity(cap_value);
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 50; i++) begin
        if (i % 10 == 0) begin
          put_pct = 25 * $urandom_range(1, 3);
        end
        if ($urandom_range(0, 99) < put_pct) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) op = OP_SPARE;
          else if (pick <= 5) op = OP_PUT_BACK;
          else op = OP_PUT_FRONT;
        end else begin
          op = OP_GET;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) msg = '0;
        else if (pick == 1) msg = '1;
        else msg = $urandom();
        send_item(op, msg, $urandom_range(0, 99) < 12);
      end
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_reset_capacity();
    test_single_slot();
    test_spare_code();
    test_oversize_capacity();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("ran %0d operations, checked %0d results over %0d capacity writes",
             items_sent, results_seen, cfg_writes);
    $display("empty gets %0d, full puts %0d, waiter hand-overs %0d",
             empty_gets, full_puts, handovers);
    if (error_count == 0 && ring_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mrfi_pkg.sv
rtl/mrfi_in_stage.sv
rtl/mrfi_ring.sv
rtl/message_ring_with_front_insert.sv
verif/tb_message_ring_with_front_insert.sv
